### hdl/aesg_pkg.sv
// ----------------------------------------------------------------------------
// aesg_pkg: shared types, constants and arithmetic helpers
// Formats, item and configuration types, and the fixed-point functions used
// by the envelope engine of the stereo envelope gain stage.
// ----------------------------------------------------------------------------
package aesg_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LVL_W       = 17;
    localparam int STEP_W      = 25;
    localparam int PROG_W      = 26;
    localparam int CFG_W       = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_W      = 24;
    localparam int RND_W       = LVL_W + FRAC_W;
    localparam int MA_W        = (SAMPLE_BITS + 1 > LVL_W + 1) ? SAMPLE_BITS + 1 : LVL_W + 1;
    localparam int MB_W        = PROG_W;
    localparam int PROD_W      = MA_W + MB_W;
    localparam int SH_W        = PROD_W - 16;
    localparam int Q_DEPTH     = 2;
    localparam int QP_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W        = $clog2(Q_DEPTH + 1);

    localparam logic [LVL_W-1:0]  ONE_Q16  = LVL_W'(65536);
    localparam logic [STEP_W-1:0] ONE_Q24  = STEP_W'(16777216);
    localparam logic [RND_W-1:0]  HALF_Q24 = RND_W'(8388608);

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(3);

    localparam logic [STEP_W-1:0] RST_ATTACK  = STEP_W'(34953);
    localparam logic [STEP_W-1:0] RST_DECAY   = STEP_W'(1748);
    localparam logic [LVL_W-1:0]  RST_SUSTAIN = LVL_W'(45875);
    localparam logic [STEP_W-1:0] RST_RELEASE = STEP_W'(1165);

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_TRIGGER = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    typedef enum logic [1:0] {
        CLS_SAMPLE,
        CLS_TRIGGER,
        CLS_RELEASE,
        CLS_CLEAR
    } t_cls;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LVL,
        SEQ_LEFT,
        SEQ_RIGHT,
        SEQ_FIN
    } t_seq;

    typedef enum logic [1:0] {
        MS_ENV,
        MS_LVL,
        MS_LEFT,
        MS_RIGHT
    } t_msel;

    typedef struct packed {
        t_cls                           cls;
        logic signed [SAMPLE_BITS-1:0]  left;
        logic signed [SAMPLE_BITS-1:0]  right;
        logic                           present;
    } t_item;

    typedef struct packed {
        logic [STEP_W-1:0] attack_step;
        logic [STEP_W-1:0] decay_step;
        logic [LVL_W-1:0]  sustain_level;
        logic [STEP_W-1:0] release_step;
    } t_cfg;

    function automatic t_cls classify(input logic [1:0] kind);
        t_cls c;
        case (kind)
            KIND_SAMPLE:  c = CLS_SAMPLE;
            KIND_TRIGGER: c = CLS_TRIGGER;
            KIND_RELEASE: c = CLS_RELEASE;
            KIND_CLEAR:   c = CLS_CLEAR;
            default:      c = CLS_SAMPLE;
        endcase
        return c;
    endfunction

    function automatic logic [LVL_W-1:0] sat_q16(input logic [LVL_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic logic [STEP_W-1:0] clamp_prog(input logic [PROG_W-1:0] p);
        return (p > PROG_W'(ONE_Q24)) ? ONE_Q24 : p[STEP_W-1:0];
    endfunction

    function automatic logic [STEP_W-1:0] prog_factor(input t_stage st,
                                                      input logic [STEP_W-1:0] p);
        return (st == ST_RELEASE) ? (ONE_Q24 - p) : p;
    endfunction

    function automatic logic [LVL_W-1:0] env_coef(input t_stage st,
                                                  input logic [LVL_W-1:0] lv,
                                                  input logic [LVL_W-1:0] sus,
                                                  input logic [LVL_W-1:0] rs);
        logic [LVL_W-1:0] c;
        case (st)
            ST_ATTACK:  c = ONE_Q16 - lv;
            ST_DECAY:   c = ONE_Q16 - sus;
            ST_RELEASE: c = rs;
            default:    c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [LVL_W-1:0] env_mix(input t_stage st,
                                                 input logic [LVL_W-1:0] lv,
                                                 input logic [LVL_W-1:0] sus,
                                                 input logic signed [PROD_W-1:0] prod);
        logic [RND_W-1:0] q;
        logic [LVL_W-1:0] rnd;
        logic [LVL_W-1:0] e;
        q   = prod[RND_W-1:0] + HALF_Q24;
        rnd = q[RND_W-1:FRAC_W];
        case (st)
            ST_ATTACK:  e = lv + rnd;
            ST_DECAY:   e = ONE_Q16 - rnd;
            ST_SUSTAIN: e = sus;
            ST_RELEASE: e = rnd;
            default:    e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] scale_round(
        input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] t;
        logic signed [SH_W-1:0]   sh;
        logic signed [SH_W-1:0]   smax;
        logic signed [SH_W-1:0]   smin;
        logic [SAMPLE_BITS-1:0]   r;
        smax = SH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        smin = -smax - SH_W'(1);
        t    = prod + $signed(PROD_W'(32768));
        sh   = t[PROD_W-1:16];
        if (sh > smax) begin
            r = smax[SAMPLE_BITS-1:0];
        end else if (sh < smin) begin
            r = smin[SAMPLE_BITS-1:0];
        end else begin
            r = sh[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] env_sample(input logic [LVL_W-1:0] env);
        logic [SAMPLE_BITS+16:0] w;
        logic [SAMPLE_BITS:0]    v;
        logic [SAMPLE_BITS:0]    vmax;
        vmax = (SAMPLE_BITS + 1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
        w    = (SAMPLE_BITS + 17)'({env, {(SAMPLE_BITS - 1){1'b0}}})
             + (SAMPLE_BITS + 17)'(32768);
        v    = w[SAMPLE_BITS+16:16];
        return (v > vmax) ? vmax[SAMPLE_BITS-1:0] : v[SAMPLE_BITS-1:0];
    endfunction

endpackage

### hdl/aesg_front.sv
// ----------------------------------------------------------------------------
// aesg_front: input acceptance, classification and item queue
// Accepts input transactions, decodes the item kind and holds the items in a
// short queue that the envelope engine drains at its own pace.
// ----------------------------------------------------------------------------
module aesg_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_kind,
    input  logic signed [aesg_pkg::SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [aesg_pkg::SAMPLE_BITS-1:0] i_right_in,
    input  logic                                  i_input_present,
    output logic                                  o_head_valid,
    output aesg_pkg::t_item                       o_head,
    input  logic                                  i_pop
);
    import aesg_pkg::*;

    t_item           r_q [Q_DEPTH];
    logic [QP_W-1:0] r_wp;
    logic [QP_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            w_push;
    t_item           w_item;

    assign o_stall      = (r_cnt == QC_W'(Q_DEPTH));
    assign w_push       = i_valid && !o_stall;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];

    always_comb begin
        w_item.cls     = classify(i_kind);
        w_item.left    = i_left_in;
        w_item.right   = i_right_in;
        w_item.present = i_input_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QP_W'(Q_DEPTH - 1)) ? '0 : r_wp + QP_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QP_W'(Q_DEPTH - 1)) ? '0 : r_rp + QP_W'(1);
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

### hdl/aesg_back.sv
// ----------------------------------------------------------------------------
// aesg_back: envelope engine and result register
// Applies events to the envelope state and, for each sample, computes the
// envelope, the scaled channels and the next state on one shared multiplier.
// ----------------------------------------------------------------------------
module aesg_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  aesg_pkg::t_cfg                          i_cfg,
    input  logic                                    i_head_valid,
    input  aesg_pkg::t_item                         i_head,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [aesg_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [aesg_pkg::SAMPLE_BITS-1:0] o_right_out,
    output logic [aesg_pkg::LVL_W-1:0]              o_env_level
);
    import aesg_pkg::*;

    t_seq                          r_seq;
    t_seq                          n_seq;
    t_stage                        r_stage;
    t_stage                        n_stage;
    logic [LVL_W-1:0]              r_level;
    logic [LVL_W-1:0]              n_level;
    logic [PROG_W-1:0]             r_progress;
    logic [PROG_W-1:0]             n_progress;
    logic [LVL_W-1:0]              r_rstart;
    logic [LVL_W-1:0]              n_rstart;
    logic [PROG_W-1:0]             r_psum;
    logic signed [PROD_W-1:0]      r_prod;
    logic [LVL_W-1:0]              r_env;
    logic [LVL_W-1:0]              r_lvl;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_left_in;
    logic signed [SAMPLE_BITS-1:0] r_right_in;
    logic                          r_present;
    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_oleft;
    logic signed [SAMPLE_BITS-1:0] r_oright;
    logic [LVL_W-1:0]              r_oenv;

    logic                          w_out_free;
    logic                          w_is_sample;
    logic                          w_ld_item;
    logic                          w_ld_prod;
    logic                          w_ld_env;
    logic                          w_ld_lvl;
    logic                          w_ld_left;
    logic                          w_ld_out;
    logic                          w_event;
    logic                          w_commit;
    t_msel                         w_msel;
    logic [LVL_W-1:0]              w_lv;
    logic [LVL_W-1:0]              w_sus;
    logic [LVL_W-1:0]              w_rs;
    logic [LVL_W-1:0]              w_coef;
    logic [STEP_W-1:0]             w_step;
    logic [PROG_W-1:0]             w_psum;
    logic [STEP_W-1:0]             w_pf_env;
    logic [STEP_W-1:0]             w_pf_lvl;
    logic signed [MA_W-1:0]        w_a;
    logic signed [MB_W-1:0]        w_b;
    logic signed [PROD_W-1:0]      w_prod;
    logic [LVL_W-1:0]              w_mix;
    logic                          w_active;
    logic                          w_done;
    logic signed [SAMPLE_BITS-1:0] w_oleft;
    logic signed [SAMPLE_BITS-1:0] w_oright;

    assign w_out_free  = !r_ovalid || !i_stall;
    assign w_is_sample = (i_head.cls == CLS_SAMPLE);

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE: begin
                if (i_head_valid && w_is_sample) begin
                    n_seq = SEQ_LVL;
                end
            end
            SEQ_LVL:   n_seq = SEQ_LEFT;
            SEQ_LEFT:  n_seq = SEQ_RIGHT;
            SEQ_RIGHT: n_seq = SEQ_FIN;
            SEQ_FIN: begin
                if (w_out_free) begin
                    n_seq = SEQ_IDLE;
                end
            end
            default:   n_seq = SEQ_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        w_ld_item = 1'b0;
        w_ld_prod = 1'b0;
        w_ld_env  = 1'b0;
        w_ld_lvl  = 1'b0;
        w_ld_left = 1'b0;
        w_ld_out  = 1'b0;
        w_event   = 1'b0;
        w_commit  = 1'b0;
        w_msel    = MS_ENV;
        case (r_seq)
            SEQ_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (w_is_sample) begin
                        w_ld_item = 1'b1;
                        w_ld_prod = 1'b1;
                    end else begin
                        w_event = 1'b1;
                    end
                end
            end
            SEQ_LVL: begin
                w_ld_env  = 1'b1;
                w_ld_prod = 1'b1;
                w_msel    = MS_LVL;
            end
            SEQ_LEFT: begin
                w_ld_lvl  = 1'b1;
                w_ld_prod = 1'b1;
                w_msel    = MS_LEFT;
            end
            SEQ_RIGHT: begin
                w_ld_left = 1'b1;
                w_ld_prod = 1'b1;
                w_msel    = MS_RIGHT;
            end
            SEQ_FIN: begin
                w_ld_out = w_out_free;
                w_commit = w_out_free;
            end
            default: begin
                w_msel = MS_ENV;
            end
        endcase
    end

    assign w_lv     = sat_q16(r_level);
    assign w_sus    = sat_q16(i_cfg.sustain_level);
    assign w_rs     = sat_q16(r_rstart);
    assign w_coef   = env_coef(r_stage, w_lv, w_sus, w_rs);
    assign w_psum   = r_progress + PROG_W'(w_step);
    assign w_pf_env = prog_factor(r_stage, clamp_prog(r_progress));
    assign w_pf_lvl = prog_factor(r_stage, clamp_prog(r_psum));
    assign w_mix    = env_mix(r_stage, w_lv, w_sus, r_prod);
    assign w_active = (r_stage == ST_ATTACK) || (r_stage == ST_DECAY)
                   || (r_stage == ST_RELEASE);
    assign w_done   = (r_psum[PROG_W-1:FRAC_W] != '0);

    always_comb begin
        case (r_stage)
            ST_ATTACK:  w_step = i_cfg.attack_step;
            ST_DECAY:   w_step = i_cfg.decay_step;
            ST_RELEASE: w_step = i_cfg.release_step;
            default:    w_step = '0;
        endcase
    end

    always_comb begin
        case (w_msel)
            MS_ENV: begin
                w_a = MA_W'(w_coef);
                w_b = MB_W'(w_pf_env);
            end
            MS_LVL: begin
                w_a = MA_W'(w_coef);
                w_b = MB_W'(w_pf_lvl);
            end
            MS_LEFT: begin
                w_a = MA_W'(r_left_in);
                w_b = MB_W'(r_env);
            end
            MS_RIGHT: begin
                w_a = MA_W'(r_right_in);
                w_b = MB_W'(r_env);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_a) * PROD_W'(w_b);

    always_comb begin
        n_stage    = r_stage;
        n_level    = r_level;
        n_progress = r_progress;
        n_rstart   = r_rstart;
        if (w_event) begin
            case (i_head.cls)
                CLS_TRIGGER: begin
                    n_stage    = ST_ATTACK;
                    n_progress = '0;
                end
                CLS_RELEASE: begin
                    if (r_stage != ST_IDLE && r_stage != ST_RELEASE) begin
                        n_rstart   = r_level;
                        n_stage    = ST_RELEASE;
                        n_progress = '0;
                    end
                end
                CLS_CLEAR: begin
                    n_stage    = ST_IDLE;
                    n_level    = '0;
                    n_progress = '0;
                    n_rstart   = '0;
                end
                default: begin
                    n_stage = r_stage;
                end
            endcase
        end else if (w_commit) begin
            if (!w_active) begin
                n_level = r_env;
            end else if (w_done) begin
                n_progress = '0;
                case (r_stage)
                    ST_ATTACK: begin
                        n_stage = ST_DECAY;
                        n_level = ONE_Q16;
                    end
                    ST_DECAY: begin
                        n_stage = ST_SUSTAIN;
                        n_level = w_sus;
                    end
                    default: begin
                        n_stage = ST_IDLE;
                        n_level = '0;
                    end
                endcase
            end else begin
                n_progress = r_psum;
                n_level    = r_lvl;
            end
        end
    end

    always_comb begin
        if (r_present) begin
            w_oleft  = r_left;
            w_oright = scale_round(r_prod);
        end else begin
            w_oleft  = env_sample(r_env);
            w_oright = env_sample(r_env);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SEQ_IDLE;
            r_stage    <= ST_IDLE;
            r_level    <= '0;
            r_progress <= '0;
            r_rstart   <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_stage    <= n_stage;
            r_level    <= n_level;
            r_progress <= n_progress;
            r_rstart   <= n_rstart;
            if (w_ld_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_item) begin
            r_left_in  <= i_head.left;
            r_right_in <= i_head.right;
            r_present  <= i_head.present;
            r_psum     <= w_psum;
        end
        if (w_ld_prod) begin
            r_prod <= w_prod;
        end
        if (w_ld_env) begin
            r_env <= w_mix;
        end
        if (w_ld_lvl) begin
            r_lvl <= w_mix;
        end
        if (w_ld_left) begin
            r_left <= scale_round(r_prod);
        end
        if (w_ld_out) begin
            r_oleft  <= w_oleft;
            r_oright <= w_oright;
            r_oenv   <= r_env;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_left_out  = r_oleft;
    assign o_right_out = r_oright;
    assign o_env_level = r_oenv;

endmodule

### hdl/adsr_envelope_stereo_gain.sv
// ----------------------------------------------------------------------------
// adsr_envelope_stereo_gain: stereo gain stage driven by an ADSR envelope
// Holds the configuration registers and joins the input queue to the
// envelope engine.
// ----------------------------------------------------------------------------
// Trigger, release and reset events change the envelope state and give no
// result; each sample gives one result, the two channels scaled by the current
// envelope or, with no input present, the envelope itself. An event is handled
// by the engine in its idle state; a sample runs through the idle, level, left,
// right and finish states, because a single 25 by 26 bit multiplier is used
// four times per sample (envelope, next level, left, right) before the result
// is committed. A two-entry queue in front of the engine and a result register
// behind it let inputs be accepted while a result is still waiting to be taken.
module adsr_envelope_stereo_gain (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [aesg_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [aesg_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [1:0]                              i_kind,
    input  logic signed [aesg_pkg::SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [aesg_pkg::SAMPLE_BITS-1:0] i_right_in,
    input  logic                                    i_input_present,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [aesg_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [aesg_pkg::SAMPLE_BITS-1:0] o_right_out,
    output logic [aesg_pkg::LVL_W-1:0]              o_env_level
);
    import aesg_pkg::*;

    t_cfg  r_cfg;
    logic  w_head_valid;
    t_item w_head;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step   <= RST_ATTACK;
            r_cfg.decay_step    <= RST_DECAY;
            r_cfg.sustain_level <= RST_SUSTAIN;
            r_cfg.release_step  <= RST_RELEASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ATTACK:  r_cfg.attack_step   <= i_cfg_data[STEP_W-1:0];
                REG_DECAY:   r_cfg.decay_step    <= i_cfg_data[STEP_W-1:0];
                REG_SUSTAIN: r_cfg.sustain_level <= i_cfg_data[LVL_W-1:0];
                REG_RELEASE: r_cfg.release_step  <= i_cfg_data[STEP_W-1:0];
                default:     r_cfg               <= r_cfg;
            endcase
        end
    end

    aesg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_input_present (i_input_present),
        .o_head_valid    (w_head_valid),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    aesg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out),
        .o_env_level  (o_env_level)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("engine took an item from an empty queue");

    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_head_valid)
        else $error("accepted transaction missing from the queue");

    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_env_level <= ONE_Q16))
        else $error("envelope above full scale");

    a_zero_env_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_env_level == '0)) |-> ((o_left_out == '0) && (o_right_out == '0)))
        else $error("non-zero output with a zero envelope");
`endif

endmodule

### sim/tb_adsr_envelope_stereo_gain.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_stereo_gain: self-checking testbench of the envelope gain
// A short table of directed transactions and register writes is followed by
// phases of random note sequences, each under its own register settings.
// Every accepted sample is run through a predictor of the envelope, and each
// result taken from the block is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_stereo_gain;
    import aesg_pkg::*;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_s;
        logic [SAMPLE_BITS-1:0] right_s;
        logic [LVL_W-1:0]       env;
    } t_gain_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_op;

    typedef struct {
        t_row_op                       op;
        logic [1:0]                    kind;
        logic signed [SAMPLE_BITS-1:0] left_s;
        logic signed [SAMPLE_BITS-1:0] right_s;
        logic                          present;
        bit                            has_want;
        t_gain_result                  want;
        logic [CFG_IDX_W-1:0]          reg_idx;
        logic [CFG_W-1:0]              reg_data;
    } t_stim_row;

    localparam int   RUN_LIMIT   = 400000;
    localparam int   PHASES      = 12;
    localparam int   PHASE_ITEMS = 120;
    localparam int   DRAIN_WAIT  = 16;
    localparam t_u64 UNIT_LVL    = 65536;
    localparam t_u64 UNIT_PROG   = 16777216;
    localparam t_u64 HALF_PROG   = 8388608;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic [CFG_W-1:0]       STEP_MAX  = 25'h1FFFFFF;
    localparam logic [CFG_W-1:0]       STEP_UNIT = 25'h1000000;
    localparam logic [CFG_W-1:0]       SUS_MAX   = 25'h001FFFF;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx       = '0;
    logic [CFG_W-1:0]              i_cfg_data      = '0;
    logic                          i_valid         = 1'b0;
    logic                          o_stall;
    logic [1:0]                    i_kind          = KIND_SAMPLE;
    logic signed [SAMPLE_BITS-1:0] i_left_in       = '0;
    logic signed [SAMPLE_BITS-1:0] i_right_in      = '0;
    logic                          i_input_present = 1'b0;
    logic                          o_valid;
    logic                          i_stall         = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_left_out;
    logic signed [SAMPLE_BITS-1:0] o_right_out;
    logic [LVL_W-1:0]              o_env_level;

    // Envelope predictor: configuration and state.
    logic [STEP_W-1:0] atk_step = RST_ATTACK;
    logic [STEP_W-1:0] dcy_step = RST_DECAY;
    logic [LVL_W-1:0]  sus_reg  = RST_SUSTAIN;
    logic [STEP_W-1:0] rel_step = RST_RELEASE;
    t_stage            env_stage = ST_IDLE;
    logic [LVL_W-1:0]  env_lvl   = '0;
    logic [PROG_W-1:0] env_prog  = '0;
    logic [LVL_W-1:0]  rel_from  = '0;

    t_gain_result gain_results_q[$];
    t_gain_result taken_want;
    t_stim_row    stim_table[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           items_sent     = 0;
    int           hold_len       = 0;
    bit           send_calm      = 1'b0;
    bit           recv_calm      = 1'b0;

    adsr_envelope_stereo_gain u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_input_present (i_input_present),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out),
        .o_env_level     (o_env_level)
    );

    always begin
        #1;
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic t_u64 sustain_clamped();
        t_u64 s;
        s = sus_reg;
        return (s > UNIT_LVL) ? UNIT_LVL : s;
    endfunction

    function automatic logic [LVL_W-1:0] envelope_value();
        t_u64 p;
        t_u64 lv;
        t_u64 s;
        t_u64 r;
        t_u64 e;
        p  = env_prog;
        lv = env_lvl;
        r  = rel_from;
        p  = (p > UNIT_PROG) ? UNIT_PROG : p;
        lv = (lv > UNIT_LVL) ? UNIT_LVL : lv;
        r  = (r > UNIT_LVL) ? UNIT_LVL : r;
        s  = sustain_clamped();
        case (env_stage)
            ST_ATTACK:  e = lv + (((UNIT_LVL - lv) * p + HALF_PROG) >> 24);
            ST_DECAY:   e = UNIT_LVL - (((UNIT_LVL - s) * p + HALF_PROG) >> 24);
            ST_SUSTAIN: e = s;
            ST_RELEASE: e = (r * (UNIT_PROG - p) + HALF_PROG) >> 24;
            default:    e = 0;
        endcase
        return e[LVL_W-1:0];
    endfunction

    task automatic advance_envelope();
        logic [STEP_W-1:0] step;
        if (env_stage == ST_ATTACK) begin
            step = atk_step;
        end else if (env_stage == ST_DECAY) begin
            step = dcy_step;
        end else if (env_stage == ST_RELEASE) begin
            step = rel_step;
        end else begin
            env_lvl = envelope_value();
            return;
        end
        env_prog = env_prog + PROG_W'(step);
        env_lvl  = envelope_value();
        if (t_u64'(env_prog) >= UNIT_PROG) begin
            env_prog = '0;
            if (env_stage == ST_ATTACK) begin
                env_stage = ST_DECAY;
                env_lvl   = LVL_W'(UNIT_LVL);
            end else if (env_stage == ST_DECAY) begin
                env_stage = ST_SUSTAIN;
                env_lvl   = LVL_W'(sustain_clamped());
            end else begin
                env_stage = ST_IDLE;
                env_lvl   = '0;
            end
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] gain_sample(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic [LVL_W-1:0]              env);
        longint acc;
        acc = longint'(x) * longint'(env) + 32768;
        acc = acc >>> 16;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
        end else if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
        end
        return acc[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] level_as_sample(input logic [LVL_W-1:0] env);
        t_u64 v;
        v = env;
        v = ((v << (SAMPLE_BITS - 1)) + 32768) >> 16;
        if (v > t_u64'(SAMPLE_MAX)) begin
            v = t_u64'(SAMPLE_MAX);
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic predict_gain(input logic [1:0] k,
                                input logic signed [SAMPLE_BITS-1:0] l,
                                input logic signed [SAMPLE_BITS-1:0] r,
                                input logic p,
                                output bit made,
                                output t_gain_result res);
        logic [LVL_W-1:0] env;
        made = 1'b0;
        res  = '0;
        if (k == KIND_TRIGGER) begin
            env_stage = ST_ATTACK;
            env_prog  = '0;
        end else if (k == KIND_RELEASE) begin
            if (env_stage != ST_IDLE && env_stage != ST_RELEASE) begin
                rel_from  = env_lvl;
                env_stage = ST_RELEASE;
                env_prog  = '0;
            end
        end else if (k == KIND_CLEAR) begin
            env_stage = ST_IDLE;
            env_lvl   = '0;
            env_prog  = '0;
            rel_from  = '0;
        end else begin
            env = envelope_value();
            if (p) begin
                res.left_s  = gain_sample(l, env);
                res.right_s = gain_sample(r, env);
            end else begin
                res.left_s  = level_as_sample(env);
                res.right_s = res.left_s;
            end
            res.env = env;
            made    = 1'b1;
            advance_envelope();
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_stim_row item_row(input logic [1:0] k,
                                           input logic signed [SAMPLE_BITS-1:0] l,
                                           input logic signed [SAMPLE_BITS-1:0] r,
                                           input logic p);
        t_stim_row row;
        row.op       = ROW_ITEM;
        row.kind     = k;
        row.left_s   = l;
        row.right_s  = r;
        row.present  = p;
        row.has_want = 1'b0;
        row.want     = '0;
        row.reg_idx  = '0;
        row.reg_data = '0;
        return row;
    endfunction

    function automatic t_stim_row known_row(input logic signed [SAMPLE_BITS-1:0] l,
                                            input logic signed [SAMPLE_BITS-1:0] r,
                                            input logic p,
                                            input logic [SAMPLE_BITS-1:0] wl,
                                            input logic [SAMPLE_BITS-1:0] wr,
                                            input logic [LVL_W-1:0] we);
        t_stim_row row;
        row              = item_row(KIND_SAMPLE, l, r, p);
        row.has_want     = 1'b1;
        row.want.left_s  = wl;
        row.want.right_s = wr;
        row.want.env     = we;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        t_stim_row row;
        row          = item_row(KIND_SAMPLE, '0, '0, 1'b0);
        row.op       = ROW_REG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    // Called at a clock edge; returns at the edge where the transaction is taken.
    task automatic send_item(input logic [1:0] k,
                             input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r,
                             input logic p,
                             input bit has_want,
                             input t_gain_result want);
        int           gap;
        bit           made;
        t_gain_result res;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind          <= k;
        i_left_in       <= l;
        i_right_in      <= r;
        i_input_present <= p;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        items_sent++;
        predict_gain(k, l, r, p, made, res);
        if (made) begin
            gain_results_q.push_back(has_want ? want : res);
        end
    endtask

    task automatic send_random(input logic [1:0] k);
        send_item(k, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (gain_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ATTACK:  atk_step = data[STEP_W-1:0];
            REG_DECAY:   dcy_step = data[STEP_W-1:0];
            REG_SUSTAIN: sus_reg  = data[LVL_W-1:0];
            REG_RELEASE: rel_step = data[STEP_W-1:0];
            default:     ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_step();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return STEP_MAX;
            2:       return STEP_UNIT;
            3:       return CFG_W'($urandom_range(1, 200));
            4:       return CFG_W'($urandom_range(32'h1000001, 32'h1FFFFFF));
            default: return CFG_W'($urandom_range(32'h1000000 / 48, 32'hFFFFFF));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_sustain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SUS_MAX;
            2:       return CFG_W'(UNIT_LVL);
            3:       return CFG_W'($urandom_range(65537, 131071));
            default: return CFG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic program_phase(input int ph);
        settle();
        if (ph == 0) begin
            write_reg(REG_ATTACK, STEP_MAX);
            write_reg(REG_DECAY, STEP_MAX);
            write_reg(REG_SUSTAIN, SUS_MAX);
            write_reg(REG_RELEASE, STEP_MAX);
        end else if (ph == 1) begin
            write_reg(REG_ATTACK, '0);
            write_reg(REG_DECAY, '0);
            write_reg(REG_SUSTAIN, '0);
            write_reg(REG_RELEASE, '0);
        end else begin
            write_reg(REG_ATTACK, pick_step());
            write_reg(REG_DECAY, pick_step());
            write_reg(REG_SUSTAIN, pick_sustain());
            write_reg(REG_RELEASE, pick_step());
        end
    endtask

    // Result side: a random hold-off before each transaction, or a long one on request.
    initial begin
        int w;
        forever begin
            if (hold_len > 0) begin
                w        = hold_len;
                hold_len = 0;
            end else begin
                w = recv_calm ? 0 : $urandom_range(0, 13);
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_valid === 1'b1));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (gain_results_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, level %0h", o_env_level));
            end else begin
                taken_want = gain_results_q.pop_front();
                if (o_left_out !== taken_want.left_s) begin
                    report_mismatch($sformatf("left got %h wanted %h",
                                              o_left_out, taken_want.left_s));
                end
                if (o_right_out !== taken_want.right_s) begin
                    report_mismatch($sformatf("right got %h wanted %h",
                                              o_right_out, taken_want.right_s));
                end
                if (o_env_level !== taken_want.env) begin
                    report_mismatch($sformatf("level got %h wanted %h",
                                              o_env_level, taken_want.env));
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_stim_row row;
        int        ph;
        int        n;
        int        phase_end;

        // Directed part: idle output, ignored release, extreme steps and
        // sustain, held stages, and a release that runs to completion.
        stim_table.push_back(known_row(S_MAX, S_MIN, 1'b1, '0, '0, '0));
        stim_table.push_back(known_row(S_MIN, S_MAX, 1'b0, '0, '0, '0));
        stim_table.push_back(item_row(KIND_RELEASE, S_MAX, S_MAX, 1'b1));
        stim_table.push_back(item_row(KIND_CLEAR, S_MIN, S_MIN, 1'b0));
        stim_table.push_back(known_row('0, '0, 1'b1, '0, '0, '0));
        stim_table.push_back(reg_row(REG_ATTACK, STEP_MAX));
        stim_table.push_back(item_row(KIND_TRIGGER, '0, '0, 1'b0));
        stim_table.push_back(known_row(S_MAX, S_MIN, 1'b1, '0, '0, '0));
        stim_table.push_back(known_row(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN, ONE_Q16));
        stim_table.push_back(item_row(KIND_SAMPLE, 24'h123456, -24'sd5, 1'b0));
        stim_table.push_back(reg_row(REG_SUSTAIN, SUS_MAX));
        stim_table.push_back(reg_row(REG_DECAY, '0));
        stim_table.push_back(item_row(KIND_SAMPLE, 24'sd1, -24'sd1, 1'b1));
        stim_table.push_back(item_row(KIND_SAMPLE, S_MAX, S_MIN, 1'b0));
        stim_table.push_back(reg_row(REG_DECAY, STEP_UNIT));
        stim_table.push_back(item_row(KIND_SAMPLE, '0, '0, 1'b0));
        stim_table.push_back(item_row(KIND_SAMPLE, 24'h400000, 24'hC00000, 1'b1));
        stim_table.push_back(item_row(KIND_RELEASE, '0, '0, 1'b0));
        stim_table.push_back(item_row(KIND_RELEASE, '0, '0, 1'b0));
        stim_table.push_back(reg_row(REG_RELEASE, '0));
        stim_table.push_back(item_row(KIND_SAMPLE, S_MAX, S_MIN, 1'b1));
        stim_table.push_back(item_row(KIND_TRIGGER, '1, '1, 1'b1));
        stim_table.push_back(item_row(KIND_SAMPLE, '0, '0, 1'b0));
        stim_table.push_back(reg_row(REG_RELEASE, STEP_UNIT));
        stim_table.push_back(item_row(KIND_RELEASE, '0, '0, 1'b0));
        stim_table.push_back(item_row(KIND_SAMPLE, 24'h2AAAAA, 24'hD55555, 1'b1));
        stim_table.push_back(known_row(S_MAX, S_MAX, 1'b0, '0, '0, '0));
        stim_table.push_back(item_row(KIND_CLEAR, '0, '0, 1'b0));
        stim_table.push_back(known_row(S_MAX, S_MIN, 1'b1, '0, '0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.op == ROW_REG) begin
                settle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_item(row.kind, row.left_s, row.right_s, row.present,
                          row.has_want, row.want);
            end
        end

        // Random part: mostly whole notes with random content, some noise.
        for (ph = 0; ph < PHASES; ph++) begin
            program_phase(ph);
            send_calm = (ph % 4 == 2) || (ph == 3);
            recv_calm = (ph % 4 == 2);
            if (ph == 3) begin
                hold_len = 300;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_random(2'($urandom_range(0, 3)));
                end else begin
                    send_random(KIND_TRIGGER);
                    n = $urandom_range(0, 40);
                    repeat (n) send_random(KIND_SAMPLE);
                    if ($urandom_range(0, 3) != 0) begin
                        send_random(KIND_RELEASE);
                    end
                    n = $urandom_range(0, 30);
                    repeat (n) send_random(KIND_SAMPLE);
                    if ($urandom_range(0, 7) == 0) begin
                        send_random(KIND_CLEAR);
                    end
                end
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
